// ===== rtl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants for the numeric field prefix classifier.
// ----------------------------------------------------------------------------
package fpc_pkg;

    // Parser phases
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_WS,
        PH_SIGN,
        PH_N1,
        PH_N2,
        PH_N3,
        PH_NTAIL,
        PH_I1,
        PH_I2,
        PH_I3,
        PH_I4,
        PH_I5,
        PH_I6,
        PH_I7,
        PH_Z,
        PH_ZX,
        PH_ZXD
    } phase_t;

    // Result classes
    localparam logic [2:0] CLS_DEC = 3'd0;
    localparam logic [2:0] CLS_HEX = 3'd1;
    localparam logic [2:0] CLS_INF = 3'd2;
    localparam logic [2:0] CLS_NAN = 3'd3;
    localparam logic [2:0] CLS_ERR = 3'd4;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_Y      = 8'h79;
    localparam logic [7:0] CH_Z      = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // Decoded properties of one character
    typedef struct packed {
        logic [7:0] low;     // lower-cased code
        logic       space;
        logic       sign;
        logic       minus;
        logic       hex;
        logic       tail;
    } char_info_t;

    // Result control from the parser
    typedef struct packed {
        logic       emit;
        logic [2:0] cls;
        logic       neg;
    } result_ctl_t;

endpackage

// ===== rtl/float_field_prefix_classifier.sv =====
// ----------------------------------------------------------------------------
// float_field_prefix_classifier
// Classifies the prefix of a numeric text field streamed one character per
// request: decimal, hex, infinity, nan or error, with sign and prefix length.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata               | tuser
//  --------+-----+---------------------+------------------------------------
//  s_      | in  | [7:0] char_code     | [0] field_start
//  m_      | out | [15:0] prefix_length| [2:0] field_class, [3] negative
//
//  One character per cycle is accepted while the result register is free or
//  being drained; the parser step from the input register to the result
//  register is combinational, and a result that an accepted character settles
//  loads into the result register in the step that takes it from the input.
//  Reset clears the valid flags and the parser to idle; no clearing pass.
//  A stalled result holds the result register; the input register then
//  holds one more character and s_tready falls until m_tready returns.
//
module float_field_prefix_classifier #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] field_start

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] prefix_length
    output logic [3:0]  m_tuser    // [2:0] field_class, [3] negative
);

    logic                     in_valid_reg;
    logic [7:0]               in_char_reg;
    logic                     in_start_reg;
    logic                     out_valid_reg;
    logic [2:0]               out_class_reg;
    logic                     out_neg_reg;
    logic [15:0]              out_len_reg;

    logic                     advance;
    logic                     step_en;
    fpc_pkg::char_info_t      info;
    fpc_pkg::result_ctl_t     res;
    logic [LENGTH_BITS-1:0]   res_len;

    // Pipeline moves when the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    fpc_char_class u_char_class (
        .char_code (in_char_reg),
        .info      (info)
    );

    fpc_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .char_code   (in_char_reg),
        .field_start (in_start_reg),
        .info        (info),
        .res         (res),
        .res_len     (res_len)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_en && res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && res.emit) begin
            out_class_reg <= res.cls;
            out_neg_reg   <= res.neg;
            out_len_reg   <= 16'(res_len);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_len_reg;
    assign m_tuser  = {out_neg_reg, out_class_reg};

`ifndef SYNTH
    // Error results carry neither sign nor length
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] == fpc_pkg::CLS_ERR) |-> (m_tdata == 16'd0 && !m_tuser[3]))
        else $error("error result with nonzero length or sign");

    // Nan is never negative
    a_nan_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] == fpc_pkg::CLS_NAN) |-> !m_tuser[3])
        else $error("negative nan result");

    // Only the five defined classes appear
    a_cls_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2:0] == fpc_pkg::CLS_DEC || m_tuser[2:0] == fpc_pkg::CLS_HEX ||
                      m_tuser[2:0] == fpc_pkg::CLS_INF || m_tuser[2:0] == fpc_pkg::CLS_NAN ||
                      m_tuser[2:0] == fpc_pkg::CLS_ERR))
        else $error("undefined result class");

    // A held character is not overwritten while the result side stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_char_reg) &&
                                        $stable(in_start_reg)))
        else $error("input register changed during stall");
`endif

endmodule

// ===== rtl/fpc_char_class.sv =====
// ----------------------------------------------------------------------------
// fpc_char_class
// Decodes one character: case folding and membership in the character sets.
// ----------------------------------------------------------------------------
module fpc_char_class (
    input  logic [7:0]          char_code,
    output fpc_pkg::char_info_t info
);

    logic [7:0] low;
    logic       is_digit;

    always_comb begin
        if (char_code >= fpc_pkg::CH_UP_A && char_code <= fpc_pkg::CH_UP_Z) begin
            low = char_code + fpc_pkg::CASE_GAP;
        end else begin
            low = char_code;
        end
    end

    assign is_digit = (char_code >= fpc_pkg::CH_ZERO) && (char_code <= fpc_pkg::CH_NINE);

    always_comb begin
        info.low   = low;
        info.space = (char_code == fpc_pkg::CH_SPACE) ||
                     (char_code >= fpc_pkg::CH_TAB && char_code <= fpc_pkg::CH_CR);
        info.sign  = (char_code == fpc_pkg::CH_MINUS) || (char_code == fpc_pkg::CH_PLUS);
        info.minus = (char_code == fpc_pkg::CH_MINUS);
        info.hex   = is_digit || (low >= fpc_pkg::CH_A && low <= fpc_pkg::CH_F);
        info.tail  = is_digit || (low >= fpc_pkg::CH_A && low <= fpc_pkg::CH_Z) ||
                     (char_code == fpc_pkg::CH_UNDER);
    end

endmodule

// ===== rtl/fpc_parser.sv =====
// ----------------------------------------------------------------------------
// fpc_parser
// Parser state machine: one character per step, at most one result per field.
// ----------------------------------------------------------------------------
module fpc_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step_en,
    input  logic [7:0]                char_code,
    input  logic                      field_start,
    input  fpc_pkg::char_info_t       info,
    output fpc_pkg::result_ctl_t      res,
    output logic [LENGTH_BITS-1:0]    res_len
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    fpc_pkg::phase_t          phase_reg, phase_next, phase_adv, ph;
    logic                     neg_reg, neg_next, neg_cur;
    logic [LENGTH_BITS-1:0]   count_reg, count_next, cnt;
    logic [LENGTH_BITS-1:0]   comm_reg, comm_next, comm;
    logic [LENGTH_BITS:0]     cnt_sum, comm_sum;
    logic [LENGTH_BITS-1:0]   inc1, comm2;

    // A start flag restarts the field on this very character
    assign ph      = field_start ? fpc_pkg::PH_WS : phase_reg;
    assign neg_cur = field_start ? 1'b0 : neg_reg;
    assign cnt     = field_start ? '0 : count_reg;
    assign comm    = field_start ? '0 : comm_reg;

    assign cnt_sum  = {1'b0, cnt} + (LENGTH_BITS+1)'(1);
    assign comm_sum = {1'b0, comm} + (LENGTH_BITS+1)'(2);
    assign inc1     = cnt_sum[LENGTH_BITS] ? LEN_MAX : cnt_sum[LENGTH_BITS-1:0];
    assign comm2    = comm_sum[LENGTH_BITS] ? LEN_MAX : comm_sum[LENGTH_BITS-1:0];

    // Outputs: does this character settle the field, and how
    always_comb begin
        res.emit = 1'b0;
        res.cls  = fpc_pkg::CLS_DEC;
        res.neg  = 1'b0;
        res_len  = '0;
        unique case (ph)
            fpc_pkg::PH_WS, fpc_pkg::PH_SIGN: begin
                if (!(ph == fpc_pkg::PH_WS && (info.space || info.sign)) &&
                    info.low != fpc_pkg::CH_N && info.low != fpc_pkg::CH_I &&
                    char_code != fpc_pkg::CH_ZERO) begin
                    res.emit = 1'b1;
                    res.neg  = neg_cur;
                    res_len  = cnt;
                end
            end
            fpc_pkg::PH_N1: begin
                if (info.low != fpc_pkg::CH_A) begin
                    res.emit = 1'b1;
                    res.cls  = fpc_pkg::CLS_ERR;
                end
            end
            fpc_pkg::PH_N2: begin
                if (info.low != fpc_pkg::CH_N) begin
                    res.emit = 1'b1;
                    res.cls  = fpc_pkg::CLS_ERR;
                end
            end
            fpc_pkg::PH_N3: begin
                if (char_code != fpc_pkg::CH_LPAREN) begin
                    res.emit = 1'b1;
                    res.cls  = fpc_pkg::CLS_NAN;
                    res_len  = comm;
                end
            end
            fpc_pkg::PH_NTAIL: begin
                if (!info.tail) begin
                    res.emit = 1'b1;
                    res.cls  = fpc_pkg::CLS_NAN;
                    res_len  = (char_code == fpc_pkg::CH_RPAREN) ? inc1 : comm;
                end
            end
            fpc_pkg::PH_I1: begin
                if (info.low != fpc_pkg::CH_N) begin
                    res.emit = 1'b1;
                    res.cls  = fpc_pkg::CLS_ERR;
                end
            end
            fpc_pkg::PH_I2: begin
                if (info.low != fpc_pkg::CH_F) begin
                    res.emit = 1'b1;
                    res.cls  = fpc_pkg::CLS_ERR;
                end
            end
            fpc_pkg::PH_I3, fpc_pkg::PH_I5: begin
                if (info.low != fpc_pkg::CH_I) begin
                    res.emit = 1'b1;
                    res.cls  = fpc_pkg::CLS_INF;
                    res.neg  = neg_cur;
                    res_len  = comm;
                end
            end
            fpc_pkg::PH_I4: begin
                if (info.low != fpc_pkg::CH_N) begin
                    res.emit = 1'b1;
                    res.cls  = fpc_pkg::CLS_INF;
                    res.neg  = neg_cur;
                    res_len  = comm;
                end
            end
            fpc_pkg::PH_I6: begin
                if (info.low != fpc_pkg::CH_T) begin
                    res.emit = 1'b1;
                    res.cls  = fpc_pkg::CLS_INF;
                    res.neg  = neg_cur;
                    res_len  = comm;
                end
            end
            fpc_pkg::PH_I7: begin
                res.emit = 1'b1;
                res.cls  = fpc_pkg::CLS_INF;
                res.neg  = neg_cur;
                res_len  = (info.low == fpc_pkg::CH_Y) ? inc1 : comm;
            end
            fpc_pkg::PH_Z: begin
                if (info.low != fpc_pkg::CH_X) begin
                    res.emit = 1'b1;
                    res.neg  = neg_cur;
                    res_len  = comm;
                end
            end
            fpc_pkg::PH_ZX, fpc_pkg::PH_ZXD: begin
                if (!(ph == fpc_pkg::PH_ZX && char_code == fpc_pkg::CH_DOT)) begin
                    res.emit = 1'b1;
                    res.neg  = neg_cur;
                    res.cls  = info.hex ? fpc_pkg::CLS_HEX : fpc_pkg::CLS_DEC;
                    res_len  = info.hex ? comm2 : comm;
                end
            end
            default: begin
                res.emit = 1'b0;
            end
        endcase
    end

    // Next state: advance through the token while it still matches
    always_comb begin
        phase_adv  = fpc_pkg::PH_IDLE;
        neg_next   = neg_cur;
        count_next = cnt;
        comm_next  = comm;
        unique case (ph)
            fpc_pkg::PH_WS, fpc_pkg::PH_SIGN: begin
                phase_adv = ph;
                if (ph == fpc_pkg::PH_WS && info.space) begin
                    count_next = inc1;
                end else if (ph == fpc_pkg::PH_WS && info.sign) begin
                    neg_next   = info.minus;
                    count_next = inc1;
                    phase_adv  = fpc_pkg::PH_SIGN;
                end else if (info.low == fpc_pkg::CH_N) begin
                    count_next = inc1;
                    phase_adv  = fpc_pkg::PH_N1;
                end else if (info.low == fpc_pkg::CH_I) begin
                    count_next = inc1;
                    phase_adv  = fpc_pkg::PH_I1;
                end else if (char_code == fpc_pkg::CH_ZERO) begin
                    comm_next  = cnt;
                    count_next = inc1;
                    phase_adv  = fpc_pkg::PH_Z;
                end
            end
            fpc_pkg::PH_N1: begin
                count_next = inc1;
                phase_adv  = fpc_pkg::PH_N2;
            end
            fpc_pkg::PH_N2: begin
                count_next = inc1;
                comm_next  = inc1;
                phase_adv  = fpc_pkg::PH_N3;
            end
            fpc_pkg::PH_N3: begin
                count_next = inc1;
                phase_adv  = fpc_pkg::PH_NTAIL;
            end
            fpc_pkg::PH_NTAIL: begin
                count_next = inc1;
                phase_adv  = fpc_pkg::PH_NTAIL;
            end
            fpc_pkg::PH_I1: begin
                count_next = inc1;
                phase_adv  = fpc_pkg::PH_I2;
            end
            fpc_pkg::PH_I2: begin
                count_next = inc1;
                comm_next  = inc1;
                phase_adv  = fpc_pkg::PH_I3;
            end
            fpc_pkg::PH_I3: begin
                count_next = inc1;
                phase_adv  = fpc_pkg::PH_I4;
            end
            fpc_pkg::PH_I4: begin
                count_next = inc1;
                phase_adv  = fpc_pkg::PH_I5;
            end
            fpc_pkg::PH_I5: begin
                count_next = inc1;
                phase_adv  = fpc_pkg::PH_I6;
            end
            fpc_pkg::PH_I6: begin
                count_next = inc1;
                phase_adv  = fpc_pkg::PH_I7;
            end
            fpc_pkg::PH_Z: begin
                phase_adv = fpc_pkg::PH_ZX;
            end
            fpc_pkg::PH_ZX: begin
                phase_adv = fpc_pkg::PH_ZXD;
            end
            default: begin
                phase_adv = fpc_pkg::PH_IDLE;
            end
        endcase
        // A settled field drops back to idle
        phase_next = res.emit ? fpc_pkg::PH_IDLE : phase_adv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fpc_pkg::PH_IDLE;
            neg_reg   <= 1'b0;
            count_reg <= '0;
            comm_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            count_reg <= count_next;
            comm_reg  <= comm_next;
        end
    end

endmodule

// ===== tb/tb_float_field_prefix_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_float_field_prefix_classifier
// Streams numeric text fields into the prefix classifier one character per
// request. A character-level model predicts each result, and every result is
// checked against it in order. The run mixes directed fields, a receiver
// hold-off and random fields under four traffic patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_float_field_prefix_classifier;

    localparam int          LENGTH_BITS  = 16;
    localparam int unsigned LEN_MAX      = (1 << LENGTH_BITS) - 1;
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          RANDOM_CHARS = 1840;
    localparam int          PRINT_CAP    = 100;

    typedef struct packed {
        logic [2:0]  cls;
        logic        neg;
        logic [15:0] len;
    } verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;

    float_field_prefix_classifier #(
        .LENGTH_BITS(LENGTH_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predicted classifier state
    fpc_pkg::phase_t ph        = fpc_pkg::PH_IDLE;
    logic            sgn       = 1'b0;
    int unsigned     cnt       = 0;
    int unsigned     committed = 0;

    verdict_t    verdict_q[$];
    logic [7:0]  field_buf[$];

    int unsigned errors       = 0;
    int unsigned chars_sent   = 0;
    int unsigned fields_sent  = 0;
    int unsigned results_seen = 0;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    int          hold_ticket  = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;

    function automatic int unsigned sat_len(int unsigned a, int unsigned b);
        longint unsigned sum;
        sum = longint'(a) + longint'(b);
        return (sum > LEN_MAX) ? LEN_MAX : 32'(sum);
    endfunction

    function automatic logic [7:0] fold(logic [7:0] c);
        return (c >= fpc_pkg::CH_UP_A && c <= fpc_pkg::CH_UP_Z) ? c + fpc_pkg::CASE_GAP : c;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= fpc_pkg::CH_ZERO && c <= fpc_pkg::CH_NINE;
    endfunction

    function automatic verdict_t settle(logic [2:0] cls, logic neg, int unsigned len);
        ph = fpc_pkg::PH_IDLE;
        return '{cls: cls, neg: neg, len: len[15:0]};
    endfunction

    // First character after whitespace and sign
    function automatic bit lead_char(logic [7:0] c, output verdict_t v);
        logic [7:0] l;
        l = fold(c);
        if (l == fpc_pkg::CH_N) begin
            cnt = sat_len(cnt, 1);
            ph  = fpc_pkg::PH_N1;
            return 1'b0;
        end
        if (l == fpc_pkg::CH_I) begin
            cnt = sat_len(cnt, 1);
            ph  = fpc_pkg::PH_I1;
            return 1'b0;
        end
        if (c == fpc_pkg::CH_ZERO) begin
            committed = cnt;
            cnt       = sat_len(cnt, 1);
            ph        = fpc_pkg::PH_Z;
            return 1'b0;
        end
        v = settle(fpc_pkg::CLS_DEC, sgn, cnt);
        return 1'b1;
    endfunction

    function automatic bit match_letter(logic [7:0] c, logic [7:0] want,
                                        fpc_pkg::phase_t nxt, bit inf_fallback,
                                        output verdict_t v);
        if (fold(c) == want) begin
            cnt = sat_len(cnt, 1);
            ph  = nxt;
            return 1'b0;
        end
        v = inf_fallback ? settle(fpc_pkg::CLS_INF, sgn, committed)
                         : settle(fpc_pkg::CLS_ERR, 1'b0, 0);
        return 1'b1;
    endfunction

    // Advance the model by one accepted character; 1 when a result is due
    function automatic bit classify_char(logic [7:0] c, logic start, output verdict_t v);
        logic [7:0] l;
        bit         hex;
        l   = fold(c);
        hex = is_digit(c) || (l >= fpc_pkg::CH_A && l <= fpc_pkg::CH_F);
        if (start) begin
            ph        = fpc_pkg::PH_WS;
            sgn       = 1'b0;
            cnt       = 0;
            committed = 0;
        end
        case (ph)
            fpc_pkg::PH_WS: begin
                if (c == fpc_pkg::CH_SPACE ||
                    (c >= fpc_pkg::CH_TAB && c <= fpc_pkg::CH_CR)) begin
                    cnt = sat_len(cnt, 1);
                    return 1'b0;
                end
                if (c == fpc_pkg::CH_MINUS || c == fpc_pkg::CH_PLUS) begin
                    sgn = (c == fpc_pkg::CH_MINUS);
                    cnt = sat_len(cnt, 1);
                    ph  = fpc_pkg::PH_SIGN;
                    return 1'b0;
                end
                return lead_char(c, v);
            end
            fpc_pkg::PH_SIGN: return lead_char(c, v);
            fpc_pkg::PH_N1:   return match_letter(c, fpc_pkg::CH_A, fpc_pkg::PH_N2, 1'b0, v);
            fpc_pkg::PH_N2: begin
                if (l == fpc_pkg::CH_N) begin
                    cnt       = sat_len(cnt, 1);
                    committed = cnt;
                    ph        = fpc_pkg::PH_N3;
                    return 1'b0;
                end
                v = settle(fpc_pkg::CLS_ERR, 1'b0, 0);
                return 1'b1;
            end
            fpc_pkg::PH_N3: begin
                if (c == fpc_pkg::CH_LPAREN) begin
                    cnt = sat_len(cnt, 1);
                    ph  = fpc_pkg::PH_NTAIL;
                    return 1'b0;
                end
                v = settle(fpc_pkg::CLS_NAN, 1'b0, committed);
                return 1'b1;
            end
            fpc_pkg::PH_NTAIL: begin
                if (is_digit(c) || (l >= fpc_pkg::CH_A && l <= fpc_pkg::CH_Z) ||
                    c == fpc_pkg::CH_UNDER) begin
                    cnt = sat_len(cnt, 1);
                    return 1'b0;
                end
                v = (c == fpc_pkg::CH_RPAREN)
                    ? settle(fpc_pkg::CLS_NAN, 1'b0, sat_len(cnt, 1))
                    : settle(fpc_pkg::CLS_NAN, 1'b0, committed);
                return 1'b1;
            end
            fpc_pkg::PH_I1: return match_letter(c, fpc_pkg::CH_N, fpc_pkg::PH_I2, 1'b0, v);
            fpc_pkg::PH_I2: begin
                if (l == fpc_pkg::CH_F) begin
                    cnt       = sat_len(cnt, 1);
                    committed = cnt;
                    ph        = fpc_pkg::PH_I3;
                    return 1'b0;
                end
                v = settle(fpc_pkg::CLS_ERR, 1'b0, 0);
                return 1'b1;
            end
            fpc_pkg::PH_I3: return match_letter(c, fpc_pkg::CH_I, fpc_pkg::PH_I4, 1'b1, v);
            fpc_pkg::PH_I4: return match_letter(c, fpc_pkg::CH_N, fpc_pkg::PH_I5, 1'b1, v);
            fpc_pkg::PH_I5: return match_letter(c, fpc_pkg::CH_I, fpc_pkg::PH_I6, 1'b1, v);
            fpc_pkg::PH_I6: return match_letter(c, fpc_pkg::CH_T, fpc_pkg::PH_I7, 1'b1, v);
            fpc_pkg::PH_I7: begin
                v = (l == fpc_pkg::CH_Y) ? settle(fpc_pkg::CLS_INF, sgn, sat_len(cnt, 1))
                                         : settle(fpc_pkg::CLS_INF, sgn, committed);
                return 1'b1;
            end
            fpc_pkg::PH_Z: begin
                if (l == fpc_pkg::CH_X) begin
                    ph = fpc_pkg::PH_ZX;
                    return 1'b0;
                end
                v = settle(fpc_pkg::CLS_DEC, sgn, committed);
                return 1'b1;
            end
            fpc_pkg::PH_ZX, fpc_pkg::PH_ZXD: begin
                if (ph == fpc_pkg::PH_ZX && c == fpc_pkg::CH_DOT) begin
                    ph = fpc_pkg::PH_ZXD;
                    return 1'b0;
                end
                v = hex ? settle(fpc_pkg::CLS_HEX, sgn, sat_len(committed, 2))
                        : settle(fpc_pkg::CLS_DEC, sgn, committed);
                return 1'b1;
            end
            default: begin
                ph = fpc_pkg::PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    // Send one character and record its prediction once accepted
    task automatic send_char(input logic [7:0] c, input logic start);
        verdict_t v;
        int       gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= start;
        do @(posedge aclk); while (s_tready !== 1'b1);
        chars_sent++;
        if (start)
            fields_sent++;
        if (classify_char(c, start, v))
            verdict_q.push_back(v);
    endtask

    task automatic send_text(input string s, input bit close = 1'b1);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == 0);
        if (close)
            send_char(fpc_pkg::CH_NUL, 1'b0);
    endtask

    task automatic send_field();
        for (int i = 0; i < field_buf.size(); i++)
            send_char(field_buf[i], i == 0);
    endtask

    task automatic set_traffic(input int sender_pct, input int receiver_pct);
        gap_pct   = sender_pct;
        stall_pct = receiver_pct;
    endtask

    function automatic logic [7:0] any_case(logic [7:0] c);
        return (c >= fpc_pkg::CH_A && c <= fpc_pkg::CH_Z && $urandom_range(0, 1))
               ? c - fpc_pkg::CASE_GAP : c;
    endfunction

    function automatic void push_word(string w, int keep);
        for (int i = 0; i < keep && i < w.len(); i++)
            field_buf.push_back(any_case(w[i]));
    endfunction

    function automatic logic [7:0] tail_char();
        case ($urandom_range(0, 2))
            0:       return fpc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
            1:       return any_case(fpc_pkg::CH_A + 8'($urandom_range(0, 25)));
            default: return fpc_pkg::CH_UNDER;
        endcase
    endfunction

    // Build a mostly well-formed field with random content
    function automatic void build_field();
        int keep;
        int digit;
        field_buf.delete();
        repeat ($urandom_range(0, 2))
            field_buf.push_back(($urandom_range(0, 5) == 0) ? fpc_pkg::CH_SPACE
                                : fpc_pkg::CH_TAB + 8'($urandom_range(0, 4)));
        case ($urandom_range(0, 2))
            1: field_buf.push_back(fpc_pkg::CH_MINUS);
            2: field_buf.push_back(fpc_pkg::CH_PLUS);
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: begin
                field_buf.push_back(fpc_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
                field_buf.push_back(fpc_pkg::CH_DOT);
            end
            1: begin
                keep = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 3;
                push_word("nan", keep);
                if (keep == 3 && $urandom_range(0, 2) != 0) begin
                    field_buf.push_back(fpc_pkg::CH_LPAREN);
                    repeat ($urandom_range(0, 4)) field_buf.push_back(tail_char());
                    if ($urandom_range(0, 2) != 0)
                        field_buf.push_back(fpc_pkg::CH_RPAREN);
                end
            end
            2: begin
                keep = $urandom_range(0, 1) ? (($urandom_range(0, 1)) ? 3 : 8)
                                            : $urandom_range(1, 8);
                push_word("infinity", keep);
            end
            3: begin
                field_buf.push_back(fpc_pkg::CH_ZERO);
                field_buf.push_back(any_case(fpc_pkg::CH_X));
                if ($urandom_range(0, 2) == 0)
                    field_buf.push_back(fpc_pkg::CH_DOT);
                digit = $urandom_range(0, 15);
                if ($urandom_range(0, 3) != 0)
                    field_buf.push_back(any_case((digit < 10)
                                        ? fpc_pkg::CH_ZERO + 8'(digit)
                                        : fpc_pkg::CH_A + 8'(digit - 10)));
                else
                    field_buf.push_back(8'($urandom_range(0, 255)));
            end
            4: begin
                field_buf.push_back(fpc_pkg::CH_ZERO);
                field_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: field_buf.push_back(8'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 2)) field_buf.push_back(8'($urandom_range(0, 255)));
        // leave some fields open so the next start cuts them off
        if ($urandom_range(0, 99) < 85)
            field_buf.push_back(fpc_pkg::CH_NUL);
    endfunction

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_char(8'($urandom_range(0, 255)),
                      (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) == 0));
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Result checker
    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                note_mismatch("unexpected result, class", 0, m_tuser[2:0]);
            end else begin
                want = verdict_q.pop_front();
                if (m_tuser[2:0] !== want.cls)
                    note_mismatch("field_class", want.cls, m_tuser[2:0]);
                if (m_tuser[3] !== want.neg)
                    note_mismatch("negative", want.neg, m_tuser[3]);
                if (m_tdata !== want.len)
                    note_mismatch("prefix_length", want.len, m_tdata);
            end
        end
    end

    // Result receiver with random stalls and the long hold-off
    always @(negedge aclk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin : watchdog
        int unsigned ticks;
        ticks = 0;
        while (ticks < CYCLE_LIMIT) begin
            @(posedge aclk);
            ticks++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, verdict_q.size());
        $display("status: fail");
        $finish;
    end

    task automatic test_idle_chars();
        // no start seen yet: drop these silently
        send_char(fpc_pkg::CH_ZERO + 8'd5, 1'b0);
        send_char(fpc_pkg::CH_NUL, 1'b0);
    endtask

    task automatic test_decimal();
        send_text("\011\012\013\014\015 -7");
        send_text("+");
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_nan();
        send_text("-nAn(a_Z9)");
        send_text("NAN(x");
        send_text("na");
    endtask

    task automatic test_infinity();
        send_text("-INFINITY");
        send_text("inFin");
        send_text("in");
    endtask

    task automatic test_hex();
        send_text("-0X1");
        send_text("0x.f");
        send_text("0x.g");
        send_text("0x");
        send_text("05");
    endtask

    task automatic test_restart();
        send_text("-i", 1'b0);
        send_text("8");
    endtask

    task automatic test_backpressure();
        hold_ticket++;
        repeat (30) send_text("7", 1'b0);
    endtask

    task automatic test_random();
        int unsigned mark;
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0:       set_traffic(0, 0);
                1:       set_traffic(45, 0);
                2:       set_traffic(0, 45);
                default: set_traffic(30, 30);
            endcase
            mark = chars_sent;
            while (chars_sent - mark < RANDOM_CHARS / 4) begin
                if ($urandom_range(0, 9) < 7) begin
                    build_field();
                    send_field();
                end else begin
                    send_noise();
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_traffic(0, 0);
        test_idle_chars();
        test_decimal();
        test_nan();
        test_infinity();
        test_hex();
        test_restart();
        set_traffic(0, 0);
        test_backpressure();
        test_random();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d fields (%0d characters), checked %0d results,",
                 fields_sent, chars_sent, results_seen);
        $display("including a long receiver hold-off and four traffic mixes.");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== float_field_prefix_classifier.f =====
rtl/fpc_pkg.sv
rtl/fpc_char_class.sv
rtl/fpc_parser.sv
rtl/float_field_prefix_classifier.sv
tb/tb_float_field_prefix_classifier.sv
